// ===== design/wmm_pkg.sv =====
// Shared types, sizes and helpers for the word multiset window matcher.
// No dependencies; every other design file imports this package.
package wmm_pkg;

  localparam int MaxWords   = 4;
  localparam int MaxWordLen = 8;
  localparam int MaxText    = 1048576;
  localparam int HistDepth  = MaxWords * MaxWordLen;

  localparam int LenW   = 4;
  localparam int CntW   = 3;
  localparam int WinW   = $clog2(HistDepth + 1);
  localparam int IdxW   = $clog2(HistDepth);
  localparam int PosW   = $clog2(MaxText);
  localparam int SeenW  = PosW + 1;
  localparam int WordW  = 8 * MaxWordLen;
  localparam int CfgIdxW = 3;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_WORD_LEN   = 3'd0,
    REG_WORD_COUNT = 3'd1,
    REG_PATTERN_0  = 3'd2,
    REG_PATTERN_1  = 3'd3,
    REG_PATTERN_2  = 3'd4,
    REG_PATTERN_3  = 3'd5
  } cfg_reg_t;

  typedef logic [HistDepth-1:0][7:0] hist_t;
  typedef logic [MaxWords-1:0][WordW-1:0] pattern_t;

  // Effective geometry of the window
  typedef struct packed {
    logic [LenW-1:0] len;
    logic [CntW-1:0] cnt;
    logic [WinW-1:0] win;
  } geom_t;

  // Item waiting in the compare stage
  typedef struct packed {
    logic            valid;
    logic            elig;
    logic [PosW-1:0] pos;
  } pend_t;

  // Clamp word length to 1..MaxWordLen
  function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] raw);
    logic [LenW-1:0] l;
    l = raw;
    if (l == '0) l = LenW'(1);
    if (l > LenW'(MaxWordLen)) l = LenW'(MaxWordLen);
    return l;
  endfunction

  // Clamp word count to 1..MaxWords
  function automatic logic [CntW-1:0] eff_cnt(input logic [CntW-1:0] raw);
    logic [CntW-1:0] c;
    c = raw;
    if (c == '0) c = CntW'(1);
    if (c > CntW'(MaxWords)) c = CntW'(MaxWords);
    return c;
  endfunction

endpackage

// ===== design/wmm_window.sv =====
// Byte history shift register, per-text byte counter and compare-stage register.
// Depends on wmm_pkg.
module wmm_window (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [7:0]          text_char,
  input  logic                text_start,
  input  logic                drain,
  input  wmm_pkg::geom_t      geom,
  output wmm_pkg::hist_t      hist,
  output wmm_pkg::pend_t      pend
);
  import wmm_pkg::*;

  logic [SeenW-1:0] bytes_seen;
  logic [SeenW-1:0] seen_base;
  logic [SeenW-1:0] bytes_seen_next;
  logic             counted;
  logic [PosW-1:0]  pos_next;

  // Restart the count on the first byte of a text, saturate at the limit
  always_comb begin
    seen_base = text_start ? '0 : bytes_seen;
    counted   = seen_base < SeenW'(MaxText);
    bytes_seen_next = counted ? seen_base + SeenW'(1) : seen_base;
    pos_next  = PosW'(bytes_seen_next - SeenW'(geom.win));
  end

  // Shift the newest byte into position zero
  always_ff @(posedge clk) begin
    if (take) begin
      hist <= {hist[HistDepth-2:0], text_char};
    end
  end

  // Advance the counter on each transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
    end else if (take) begin
      bytes_seen <= bytes_seen_next;
    end
  end

  // Load the compare stage on a transfer, drop it once done
  always_ff @(posedge clk) begin
    if (rst) begin
      pend.valid <= 1'b0;
    end else if (take) begin
      pend.valid <= 1'b1;
    end else if (drain) begin
      pend.valid <= 1'b0;
    end
    if (take) begin
      pend.elig <= counted && (bytes_seen_next >= SeenW'(geom.win));
      pend.pos  <= pos_next;
    end
  end

endmodule

// ===== design/wmm_match.sv =====
// Cuts the window into chunks and compares chunk and pattern multisets.
// Depends on wmm_pkg.
module wmm_match (
  input  wmm_pkg::hist_t    hist,
  input  wmm_pkg::geom_t    geom,
  input  wmm_pkg::pattern_t patterns,
  output logic              hit
);
  import wmm_pkg::*;

  logic [MaxWords-1:0][WordW-1:0] chunk;
  logic [MaxWords-1:0][WordW-1:0] pat;
  logic [WordW-1:0]               mask;

  // Gather chunk bytes from the history, oldest window byte first
  always_comb begin
    logic [WinW-1:0] off;
    logic [WinW-1:0] idx;
    chunk = '0;
    for (int i = 0; i < MaxWords; i++) begin
      for (int b = 0; b < MaxWordLen; b++) begin
        off = WinW'(i) * WinW'(geom.len) + WinW'(b);
        idx = geom.win - WinW'(1) - off;
        if ((CntW'(i) < geom.cnt) && (LenW'(b) < geom.len)) begin
          chunk[i][8*b +: 8] = hist[idx[IdxW-1:0]];
        end
      end
    end
  end

  // Keep only the bytes below the word length in each pattern
  always_comb begin
    for (int b = 0; b < MaxWordLen; b++) begin
      mask[8*b +: 8] = (LenW'(b) < geom.len) ? 8'hFF : 8'h00;
    end
    for (int i = 0; i < MaxWords; i++) begin
      pat[i] = patterns[i] & mask;
    end
  end

  // Every chunk value must occur as often among chunks as among patterns
  always_comb begin
    logic [CntW-1:0] nc;
    logic [CntW-1:0] np;
    hit = 1'b1;
    for (int i = 0; i < MaxWords; i++) begin
      nc = '0;
      np = '0;
      for (int j = 0; j < MaxWords; j++) begin
        if (CntW'(j) < geom.cnt) begin
          if (chunk[j] == chunk[i]) nc = nc + CntW'(1);
          if (pat[j] == chunk[i]) np = np + CntW'(1);
        end
      end
      if ((CntW'(i) < geom.cnt) && (nc != np)) hit = 1'b0;
    end
  end

endmodule

// ===== design/word_multiset_window_matcher_top.sv =====
// Top level of the word multiset window matcher: configuration registers,
// byte window, chunk compare and result register. Depends on wmm_pkg.
//
// The block takes one text byte per cycle while text_stall is low and reports
// the start position of every window of word_count * word_len bytes whose
// chunks equal the pattern words as a multiset. A byte is registered into the
// compare stage and waits there while the chunk compare runs on the history
// register, and a match then lands in the result register, which drives
// match_valid and waits while the result is stalled. Bytes can follow back to
// back. Input stall rises only while a finished match waits under a stalled
// result, and it follows match_stall in the same cycle. Write configuration
// only while no byte is in flight.
module word_multiset_window_matcher_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wmm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [wmm_pkg::WordW-1:0]  cfg_data,
  input  logic                       text_valid,
  output logic                       text_stall,
  input  logic [7:0]                 text_char,
  input  logic                       text_start,
  output logic                       match_valid,
  input  logic                       match_stall,
  output logic [wmm_pkg::PosW-1:0]   match_start
);
  import wmm_pkg::*;

  logic [LenW-1:0] word_len;
  logic [CntW-1:0] word_count;
  pattern_t        patterns;
  geom_t           geom;
  hist_t           hist;
  pend_t           pend;
  logic            hit;
  logic            out_free;
  logic            found;
  logic            drain;
  logic            take;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      word_len   <= LenW'(1);
      word_count <= CntW'(1);
      patterns   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORD_LEN:   word_len    <= cfg_data[LenW-1:0];
        REG_WORD_COUNT: word_count  <= cfg_data[CntW-1:0];
        REG_PATTERN_0:  patterns[0] <= cfg_data;
        REG_PATTERN_1:  patterns[1] <= cfg_data;
        REG_PATTERN_2:  patterns[2] <= cfg_data;
        REG_PATTERN_3:  patterns[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window geometry from clamped settings
  always_comb begin
    geom.len = eff_len(word_len);
    geom.cnt = eff_cnt(word_count);
    geom.win = WinW'(geom.len) * WinW'(geom.cnt);
  end

  // Handshake: a pending byte drains unless its match is blocked
  always_comb begin
    out_free   = !match_valid || !match_stall;
    found      = pend.valid && pend.elig && hit;
    drain      = pend.valid && (!found || out_free);
    text_stall = pend.valid && !drain;
    take       = text_valid && !text_stall;
  end

  wmm_window u_window (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .text_char  (text_char),
    .text_start (text_start),
    .drain      (drain),
    .geom       (geom),
    .hist       (hist),
    .pend       (pend)
  );

  wmm_match u_match (
    .hist     (hist),
    .geom     (geom),
    .patterns (patterns),
    .hit      (hit)
  );

  // Result register: load when free, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      match_valid <= 1'b0;
    end else if (out_free) begin
      match_valid <= found;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && found) begin
      match_start <= pend.pos;
    end
  end

endmodule
